FILE: hw/rtl/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dpfi_pkg.sv
package dpfi_pkg;

  localparam int DAMPER_MAX = 3;
  localparam int DAMPER_COUNT_DEF = 3;
  localparam int POS_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'((9'h080 << 1) - 9'd1);
  localparam logic [POS_W-1:0] POS_RESET = POS_W'(1);
  localparam logic [POS_W-1:0] OPEN_POS_RESET = POS_W'(100);
  localparam logic [DAMPER_MAX-1:0] INSTALLED_RESET = 3'b111;
  localparam logic [1:0] LAMINA_IDX_RESET = 2'd2;

  // item commands
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ENDSTOP = 2'd1;
  localparam logic [1:0] CMD_DAMPER = 2'd2;

  // damper codes, anything else closes the damper but opens the lamina gate
  localparam logic [1:0] CODE_CLOSED = 2'd0;
  localparam logic [1:0] CODE_OPEN = 2'd1;
  localparam logic [1:0] CODE_HALF = 2'd2;

  // fan codes, anything else forces both fans off
  localparam logic [1:0] FAN_OFF = 2'd0;
  localparam logic [1:0] FAN_ON = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INSTALLED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAMINA_IDX = 3'd4;

  typedef struct packed {
    logic tick;
    logic endstop;
    logic load;
  } lane_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic motor;
    logic timeout;
    logic reached;
    logic zero;
  } lane_stat_t;

endpackage

FILE: hw/rtl/dpfi_lane.sv
module dpfi_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dpfi_pkg::lane_ctrl_t        ctrl,
  input  logic                        installed,
  input  logic                        endstop_level,
  input  logic [1:0]                  code,
  input  logic [dpfi_pkg::POS_W-1:0]  open_pos,
  output dpfi_pkg::lane_stat_t        stat
);

  logic [dpfi_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [dpfi_pkg::POS_W-1:0] tgt_r, tgt_nxt;
  logic                       seen_r, seen_nxt;
  logic                       motor_r, motor_nxt;
  logic [dpfi_pkg::POS_W-1:0] pos_sync;
  logic                       timeout;

  always_comb begin
    pos_nxt   = pos_r;
    tgt_nxt   = tgt_r;
    seen_nxt  = seen_r;
    motor_nxt = motor_r;
    timeout   = 1'b0;
    // endstop resyncs the count before the step
    pos_sync  = seen_r ? '0 : pos_r;
    if (ctrl.tick && installed) begin
      seen_nxt = 1'b0;
      timeout  = (tgt_r == '0) && (pos_sync == dpfi_pkg::POS_MAX);
      if (pos_sync != tgt_r) begin
        motor_nxt = 1'b1;
        pos_nxt   = pos_sync + dpfi_pkg::POS_W'(1);
      end else begin
        motor_nxt = 1'b0;
        pos_nxt   = pos_sync;
      end
    end
    if (ctrl.endstop && !endstop_level && motor_r) begin
      seen_nxt = 1'b1;
    end
    if (ctrl.load) begin
      unique case (code)
        dpfi_pkg::CODE_OPEN: tgt_nxt = open_pos;
        dpfi_pkg::CODE_HALF: tgt_nxt = open_pos >> 1;
        default:             tgt_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= dpfi_pkg::POS_RESET;
      tgt_r   <= '0;
      seen_r  <= 1'b0;
      motor_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      tgt_r   <= tgt_nxt;
      seen_r  <= seen_nxt;
      motor_r <= motor_nxt;
    end
  end

  assign stat.pos     = pos_nxt;
  assign stat.motor   = motor_nxt;
  assign stat.timeout = timeout;
  assign stat.reached = (pos_nxt == tgt_nxt) || !installed;
  assign stat.zero    = (pos_nxt == '0);

endmodule

FILE: hw/rtl/dpfi_merge.sv
module dpfi_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpfi_pkg::lane_ctrl_t  ctrl,
  input  dpfi_pkg::lane_stat_t  stat [dpfi_pkg::DAMPER_MAX],
  input  logic [1:0]            codes [dpfi_pkg::DAMPER_MAX],
  input  logic [1:0]            fan_code,
  input  logic                  lamina_fan_code,
  input  logic                  all_reached,
  input  logic [1:0]            lamina_idx,
  output logic                  fan_run,
  output logic                  lamina_fan_run
);

  logic fan_tgt_r, fan_tgt_nxt;
  logic lam_tgt_r, lam_tgt_nxt;
  logic reached_all;
  logic closed_all;
  logic gate_open;

  always_comb begin
    gate_open = 1'b0;
    if (lamina_idx < 2'(dpfi_pkg::DAMPER_MAX)) begin
      gate_open = (codes[lamina_idx] != dpfi_pkg::CODE_CLOSED);
    end
    fan_tgt_nxt = fan_tgt_r;
    lam_tgt_nxt = lam_tgt_r;
    if (ctrl.load && all_reached) begin
      case (fan_code) inside
        dpfi_pkg::FAN_OFF, dpfi_pkg::FAN_ON: begin
          fan_tgt_nxt = (fan_code == dpfi_pkg::FAN_ON);
          if (gate_open) begin
            lam_tgt_nxt = lamina_fan_code;
          end
        end
        default: begin
          fan_tgt_nxt = 1'b0;
          lam_tgt_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    reached_all = 1'b1;
    closed_all  = 1'b1;
    for (int d = 0; d < dpfi_pkg::DAMPER_MAX; d++) begin
      reached_all = reached_all && stat[d].reached;
      closed_all  = closed_all && stat[d].zero;
    end
  end

  // interlock on the state left by this item
  assign fan_run        = fan_tgt_nxt && reached_all && !closed_all;
  assign lamina_fan_run = lam_tgt_nxt && reached_all && fan_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_tgt_r <= 1'b0;
      lam_tgt_r <= 1'b0;
    end else begin
      fan_tgt_r <= fan_tgt_nxt;
      lam_tgt_r <= lam_tgt_nxt;
    end
  end

endmodule

FILE: hw/rtl/damper_position_and_fan_interlock.sv
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  command, endstop levels, codes, fan request
// out_      output     out_valid/out_stall motors, fans, timeouts, positions
// cfg_      input      cfg_we             cfg_index, cfg_wdata
// lanes and interlock settle in the accepting cycle,
// the result sits in the output register the cycle after
// an item is taken every cycle while the output register is free or being emptied
// in_stall follows out_stall only while a result is held
// synchronous reset: positions 1, targets, flags, motors and fan targets 0
`include "assert_macros.svh"

module damper_position_and_fan_interlock #(
  parameter int DAMPER_COUNT = dpfi_pkg::DAMPER_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [2:0]                          in_endstop_levels,
  input  logic [1:0]                          in_damper0_code,
  input  logic [1:0]                          in_damper1_code,
  input  logic [1:0]                          in_damper2_code,
  input  logic [1:0]                          in_fan_code,
  input  logic                                in_lamina_fan_code,
  input  logic                                in_all_reached,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_motor_run,
  output logic                                out_fan_run,
  output logic                                out_lamina_fan_run,
  output logic [2:0]                          out_timeout_flags,
  output logic [7:0]                          out_position_0,
  output logic [7:0]                          out_position_1,
  output logic [7:0]                          out_position_2,
  input  logic                                cfg_we,
  input  logic [dpfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpfi_pkg::POS_W-1:0]          cfg_wdata
);

  logic [dpfi_pkg::POS_W-1:0]     open_pos_r [dpfi_pkg::DAMPER_MAX];
  logic [dpfi_pkg::DAMPER_MAX-1:0] installed_r;
  logic [1:0]                     lamina_idx_r;

  logic                 in_accept;
  dpfi_pkg::lane_ctrl_t ctrl;
  dpfi_pkg::lane_stat_t stat [dpfi_pkg::DAMPER_MAX];
  logic [1:0]           codes [dpfi_pkg::DAMPER_MAX];
  logic                 fan_run;
  logic                 lamina_fan_run;

  logic                       out_valid_r, out_valid_nxt;
  logic [2:0]                 motor_r, timeout_r;
  logic                       fan_r, lamina_r;
  logic [dpfi_pkg::POS_W-1:0] pos0_r, pos1_r, pos2_r;
  logic [2:0]                 motor_nxt, timeout_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign ctrl.tick    = in_accept && (in_command == dpfi_pkg::CMD_TICK);
  assign ctrl.endstop = in_accept && (in_command == dpfi_pkg::CMD_ENDSTOP);
  assign ctrl.load    = in_accept && (in_command == dpfi_pkg::CMD_DAMPER);

  assign codes[0] = in_damper0_code;
  assign codes[1] = in_damper1_code;
  assign codes[2] = in_damper2_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < dpfi_pkg::DAMPER_MAX; d++) begin
        open_pos_r[d] <= dpfi_pkg::OPEN_POS_RESET;
      end
      installed_r  <= dpfi_pkg::INSTALLED_RESET;
      lamina_idx_r <= dpfi_pkg::LAMINA_IDX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        dpfi_pkg::REG_OPEN_0, dpfi_pkg::REG_OPEN_1, dpfi_pkg::REG_OPEN_2:
          open_pos_r[cfg_index[1:0]] <= cfg_wdata;
        dpfi_pkg::REG_INSTALLED:  installed_r  <= cfg_wdata[dpfi_pkg::DAMPER_MAX-1:0];
        dpfi_pkg::REG_LAMINA_IDX: lamina_idx_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  for (genvar d = 0; d < dpfi_pkg::DAMPER_MAX; d++) begin : g_lane
    if (d < DAMPER_COUNT) begin : g_on
      dpfi_lane u_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .installed     (installed_r[d]),
        .endstop_level (in_endstop_levels[d]),
        .code          (codes[d]),
        .open_pos      (open_pos_r[d]),
        .stat          (stat[d])
      );
    end else begin : g_off
      // absent damper: frozen at reset position, neutral for the interlock
      assign stat[d].pos     = dpfi_pkg::POS_RESET;
      assign stat[d].motor   = 1'b0;
      assign stat[d].timeout = 1'b0;
      assign stat[d].reached = 1'b1;
      assign stat[d].zero    = 1'b1;
    end
  end

  dpfi_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .codes           (codes),
    .fan_code        (in_fan_code),
    .lamina_fan_code (in_lamina_fan_code),
    .all_reached     (in_all_reached),
    .lamina_idx      (lamina_idx_r),
    .fan_run         (fan_run),
    .lamina_fan_run  (lamina_fan_run)
  );

  always_comb begin
    for (int d = 0; d < dpfi_pkg::DAMPER_MAX; d++) begin
      motor_nxt[d]   = stat[d].motor;
      timeout_nxt[d] = stat[d].timeout;
    end
  end

  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      motor_r   <= motor_nxt;
      timeout_r <= timeout_nxt;
      fan_r     <= fan_run;
      lamina_r  <= lamina_fan_run;
      pos0_r    <= stat[0].pos;
      pos1_r    <= stat[1].pos;
      pos2_r    <= stat[2].pos;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_run      = motor_r;
  assign out_fan_run        = fan_r;
  assign out_lamina_fan_run = lamina_r;
  assign out_timeout_flags  = timeout_r;
  assign out_position_0     = pos0_r;
  assign out_position_1     = pos1_r;
  assign out_position_2     = pos2_r;

  `ASSERT_CLK(a_timeout_tick_only, clk, rst_n, in_accept && (in_command != dpfi_pkg::CMD_TICK) |=> out_timeout_flags == 3'b000, "timeout flag outside a tick")
  `ASSERT_CLK(a_lamina_needs_fan, clk, rst_n, out_valid_r && out_lamina_fan_run |-> out_fan_run, "laminar fan runs without main fan")
  `ASSERT_CLK(a_absent_motor_off, clk, rst_n, out_valid_r |-> (out_motor_run >> DAMPER_COUNT) == 3'b000, "motor bit set for absent damper")
  `ASSERT_CLK_ALWAYS(a_reset_no_valid, clk, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
